FILE: rtl/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

  // One quotient bit per cell; both quotients stay below 2**DIV_STEPS.
  localparam int unsigned DIV_STEPS = 16;

  localparam logic [14:0] HUE_GREEN = 15'd7680;
  localparam logic [14:0] HUE_BLUE  = 15'd15360;
  localparam logic [14:0] HUE_FULL  = 15'd23040;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } rhc_sector_e;

  // Restoring division state: remainder, dividend bits still to shift in
  // on the high end of word, quotient bits collected on its low end.
  typedef struct packed {
    logic [7:0]           rem;
    logic [DIV_STEPS-1:0] word;
    logic [7:0]           divisor;
  } rhc_lane_t;

  typedef struct packed {
    rhc_sector_e sector;
    logic        neg;
    logic [7:0]  value;
    logic        ach;
  } rhc_side_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [7:0]  value;
    logic        ach;
  } rhc_result_t;

endpackage

`default_nettype wire

FILE: rtl/rhc_prep.sv
`default_nettype none

module rhc_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               valid_o,
  output rhc_pkg::rhc_lane_t sat_lane_o,
  output rhc_pkg::rhc_lane_t hue_lane_o,
  output rhc_pkg::rhc_side_t side_o
);
  import rhc_pkg::*;

  logic        valid_q;
  rhc_lane_t   sat_lane_d, sat_lane_q;
  rhc_lane_t   hue_lane_d, hue_lane_q;
  rhc_side_t   side_d, side_q;
  logic [7:0]  mx, mn, delta, plus, minus, mag;
  logic [23:0] sat_num;
  logic [19:0] hue_num;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;

    // red wins ties, then green
    if (red_i >= green_i && red_i >= blue_i) begin
      side_d.sector = SECTOR_RED;
      plus  = green_i;
      minus = blue_i;
    end else if (green_i >= blue_i) begin
      side_d.sector = SECTOR_GREEN;
      plus  = blue_i;
      minus = red_i;
    end else begin
      side_d.sector = SECTOR_BLUE;
      plus  = red_i;
      minus = green_i;
    end
    side_d.neg   = plus < minus;
    mag          = side_d.neg ? (minus - plus) : (plus - minus);
    side_d.value = mx;
    side_d.ach   = (delta == 8'd0);

    // delta * 65535 and mag * 3840 as shifts and subtracts
    sat_num = {delta, 16'd0} - {16'd0, delta};
    hue_num = {mag, 12'd0} - {4'd0, mag, 8'd0};

    sat_lane_d.rem     = sat_num[23:16];
    sat_lane_d.word    = sat_num[15:0];
    sat_lane_d.divisor = mx;
    hue_lane_d.rem     = {4'd0, hue_num[19:16]};
    hue_lane_d.word    = hue_num[15:0];
    hue_lane_d.divisor = delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_lane_q <= sat_lane_d;
      hue_lane_q <= hue_lane_d;
      side_q     <= side_d;
    end
  end

  assign valid_o    = valid_q;
  assign sat_lane_o = sat_lane_q;
  assign hue_lane_o = hue_lane_q;
  assign side_o     = side_q;

endmodule

`default_nettype wire

FILE: rtl/rhc_div_cell.sv
`default_nettype none

module rhc_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rhc_pkg::rhc_lane_t sat_lane_i,
  input  rhc_pkg::rhc_lane_t hue_lane_i,
  input  rhc_pkg::rhc_side_t side_i,
  output logic               valid_o,
  output rhc_pkg::rhc_lane_t sat_lane_o,
  output rhc_pkg::rhc_lane_t hue_lane_o,
  output rhc_pkg::rhc_side_t side_o
);
  import rhc_pkg::*;

  logic      valid_q;
  rhc_lane_t sat_lane_d, sat_lane_q;
  rhc_lane_t hue_lane_d, hue_lane_q;
  rhc_side_t side_q;

  function automatic rhc_lane_t div_step(input rhc_lane_t lane);
    rhc_lane_t  res;
    logic [8:0] trial;
    logic       fits;
    trial = {lane.rem, lane.word[DIV_STEPS-1]};
    fits  = trial >= {1'b0, lane.divisor};
    res.divisor = lane.divisor;
    res.rem     = fits ? 8'(trial - {1'b0, lane.divisor}) : trial[7:0];
    res.word    = {lane.word[DIV_STEPS-2:0], fits};
    return res;
  endfunction

  always_comb begin
    sat_lane_d = div_step(sat_lane_i);
    hue_lane_d = div_step(hue_lane_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_lane_q <= sat_lane_d;
      hue_lane_q <= hue_lane_d;
      side_q     <= side_i;
    end
  end

  assign valid_o    = valid_q;
  assign sat_lane_o = sat_lane_q;
  assign hue_lane_o = hue_lane_q;
  assign side_o     = side_q;

endmodule

`default_nettype wire

FILE: rtl/rhc_out.sv
`default_nettype none

module rhc_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rhc_pkg::rhc_lane_t   sat_lane_i,
  input  rhc_pkg::rhc_lane_t   hue_lane_i,
  input  rhc_pkg::rhc_side_t   side_i,
  input  logic                 ready_i,
  output logic                 en_o,
  output logic                 valid_o,
  output rhc_pkg::rhc_result_t result_o
);
  import rhc_pkg::*;

  rhc_result_t res_d;
  rhc_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic [14:0] quot;
  logic        neg;
  logic        take, push;

  always_comb begin
    quot = {3'd0, hue_lane_i.word[11:0]};
    // a zero quotient carries no sign
    neg  = side_i.neg && (quot != 15'd0);
    case (side_i.sector)
      SECTOR_RED:   res_d.hue = neg ? (HUE_FULL - quot) : quot;
      SECTOR_GREEN: res_d.hue = neg ? (HUE_GREEN - quot) : (HUE_GREEN + quot);
      SECTOR_BLUE:  res_d.hue = neg ? (HUE_BLUE - quot) : (HUE_BLUE + quot);
      default:      res_d.hue = 15'd0;
    endcase
    res_d.sat   = sat_lane_i.word;
    res_d.value = side_i.value;
    res_d.ach   = side_i.ach;
    if (side_i.ach) begin
      res_d.hue = 15'd0;
      res_d.sat = 16'd0;
    end
  end

  assign en_o = !skid_valid_q;
  assign take = out_valid_q && ready_i;
  assign push = en_o && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !take) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !take) skid_q <= res_d;
      else out_q <= res_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/rgb_to_hsv_converter.sv
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   24    red, green, blue
// m_axis    out  40    hue, saturation, value; tuser = achromatic flag
//
// The pipeline has one prepare stage, sixteen division cells (one
// quotient bit each for saturation and hue), and the output register.
// One pixel per clock is accepted and delivered while the output drains.
// Reset clears only the valid bits of the stages and of the output pair.
// A stalled output fills a one-entry skid register; only then does the
// whole chain hold and s_axis_tready drop.

module rgb_to_hsv_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // hue_out, sat_out, value_out, zero pad
  output logic        m_axis_tuser    // achromatic
);
  import rhc_pkg::*;

  logic        en;
  logic        valid  [DIV_STEPS+1];
  rhc_lane_t   sat_lane [DIV_STEPS+1];
  rhc_lane_t   hue_lane [DIV_STEPS+1];
  rhc_side_t   side   [DIV_STEPS+1];
  rhc_result_t result;

  rhc_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .red_i      (s_axis_tdata[7:0]),
    .green_i    (s_axis_tdata[15:8]),
    .blue_i     (s_axis_tdata[23:16]),
    .valid_o    (valid[0]),
    .sat_lane_o (sat_lane[0]),
    .hue_lane_o (hue_lane[0]),
    .side_o     (side[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (valid[i]),
      .sat_lane_i (sat_lane[i]),
      .hue_lane_i (hue_lane[i]),
      .side_i     (side[i]),
      .valid_o    (valid[i+1]),
      .sat_lane_o (sat_lane[i+1]),
      .hue_lane_o (hue_lane[i+1]),
      .side_o     (side[i+1])
    );
  end

  rhc_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid[DIV_STEPS]),
    .sat_lane_i (sat_lane[DIV_STEPS]),
    .hue_lane_i (hue_lane[DIV_STEPS]),
    .side_i     (side[DIV_STEPS]),
    .ready_i    (m_axis_tready),
    .en_o       (en),
    .valid_o    (m_axis_tvalid),
    .result_o   (result)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = {1'b0, result.value, result.sat, result.hue};
  assign m_axis_tuser  = result.ach;

`ifndef NO_ASSERTIONS
  // the chain only holds while a finished result waits
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid) else $error("stall without pending output");

  a_ach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[30:0] == 31'd0))
    else $error("achromatic result with nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:0] < HUE_FULL)) else $error("hue out of range");

  a_black_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[38:31] == 8'd0)) |-> m_axis_tuser)
    else $error("black pixel not achromatic");
`endif

endmodule

`default_nettype wire
